@@ rtl/prac_pkg.sv @@
// Shared constants and the gain-reciprocal function for the point rotation block.
`timescale 1ns / 1ps

package prac_pkg;

    // Guard bits carried below the Q16.16 point through the rotation stages.
    localparam int GUARD = 8;

    // Angles run internally as 32-bit turns: 2^32 is one full turn.
    localparam int TURN_WIDTH = 32;

    // The gain reciprocal is a Q30 value below one.
    localparam int KQ_FRAC  = 30;
    localparam int KQ_WIDTH = 31;

    // Arctangent of 2^-i in 32-bit turns.
    localparam logic [TURN_WIDTH-1:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Reciprocal of the CORDIC gain for a given stage count, in Q30.
    // Evaluated only at elaboration: integer square root by the bit method,
    // then a rounded quotient by shift and subtract.
    function automatic logic [KQ_WIDTH-1:0] gain_recip(input int stages);
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bit_v;
        logic [63:0] g;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        p = 64'd1 << 60;
        for (int i = 0; i < stages && i < 32; i++)
        begin
            p = p + (p >> (2 * i));
        end
        n     = p;
        root  = 64'd0;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (bit_v > n)
            begin
                bit_v = bit_v >> 2;
            end
        end
        for (int k = 0; k < 32; k++)
        begin
            if (bit_v != 64'd0)
            begin
                if (n >= root + bit_v)
                begin
                    n    = n - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end
                else
                begin
                    root = root >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        g = (root == 64'd0) ? 64'd1 : root;
        num = (64'd1 << 60) + (g >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= g)
            begin
                rem    = rem - g;
                quo[k] = 1'b1;
            end
        end
        return quo[KQ_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/prac_plane_rot.sv @@
// Pipelined CORDIC rotation of a planar offset, with gain removal and rounding.
`timescale 1ns / 1ps

module prac_plane_rot #(
    parameter int IW     = 33,
    parameter int AW     = 16,
    parameter int SW     = 8,
    parameter int STAGES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] in_a,
    input  logic signed [IW-1:0] in_b,
    input  logic        [AW-1:0] in_ang,
    input  logic        [SW-1:0] in_side,
    output logic                 out_valid,
    output logic signed [IW+1:0] out_a,
    output logic signed [IW+1:0] out_b,
    output logic        [SW-1:0] out_side
);
    import prac_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Datapath width through the stages: offset, quadrant sign, guard bits
    // and the growth of the CORDIC gain.
    localparam int DW = IW + GUARD + 3;
    localparam int MW = (DW > KQ_FRAC + 1) ? DW : KQ_FRAC + 1;
    localparam int HW = MW - KQ_FRAC;
    localparam int PHW = HW + KQ_WIDTH;
    localparam int PLW = KQ_FRAC + KQ_WIDTH;
    localparam int RW = PHW + 1;
    localparam int OW = IW + 2;
    localparam logic [KQ_WIDTH-1:0] KQ = gain_recip(STAGES);
    localparam logic signed [RW:0] RND_HALF = (RW + 1)'(1) << (GUARD - 1);

    // Quadrant step.
    logic [TURN_WIDTH-1:0] turn;
    logic [TURN_WIDTH-1:0] turn_bias;
    logic [1:0]            quad;
    logic [TURN_WIDTH-1:0] resid;
    logic signed [IW:0]    ax;
    logic signed [IW:0]    bx;
    logic signed [IW:0]    qa;
    logic signed [IW:0]    qb;

    always_comb
    begin
        turn      = {in_ang, {(TURN_WIDTH - AW){1'b0}}};
        turn_bias = turn + 32'h2000_0000;
        quad      = turn_bias[TURN_WIDTH-1:TURN_WIDTH-2];
        resid     = turn - {quad, {(TURN_WIDTH - 2){1'b0}}};
        ax        = (IW + 1)'(in_a);
        bx        = (IW + 1)'(in_b);
        case (quad)
            QUAD_0:
            begin
                qa = ax;
                qb = bx;
            end
            QUAD_1:
            begin
                qa = -bx;
                qb = ax;
            end
            QUAD_2:
            begin
                qa = -ax;
                qb = -bx;
            end
            QUAD_3:
            begin
                qa = bx;
                qb = -ax;
            end
            default:
            begin
                qa = ax;
                qb = bx;
            end
        endcase
    end

    logic signed [DW-1:0]         a_reg    [0:STAGES];
    logic signed [DW-1:0]         b_reg    [0:STAGES];
    logic signed [TURN_WIDTH-1:0] z_reg    [0:STAGES];
    logic        [SW-1:0]         side_reg [0:STAGES];
    logic signed [DW-1:0]         a_next   [0:STAGES];
    logic signed [DW-1:0]         b_next   [0:STAGES];
    logic signed [TURN_WIDTH-1:0] z_next   [0:STAGES];
    logic        [STAGES:0]       v_reg;

    assign a_next[0] = {{(DW - IW - 1 - GUARD){qa[IW]}}, qa, {GUARD{1'b0}}};
    assign b_next[0] = {{(DW - IW - 1 - GUARD){qb[IW]}}, qb, {GUARD{1'b0}}};
    assign z_next[0] = $signed(resid);

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [TURN_WIDTH-1:0] ATAN_I = $signed(ATAN_TURNS[i]);
        logic signed [DW-1:0] da;
        logic signed [DW-1:0] db;
        assign da = b_reg[i] >>> i;
        assign db = a_reg[i] >>> i;
        assign a_next[i+1] = (z_reg[i] >= 0) ? a_reg[i] - da : a_reg[i] + da;
        assign b_next[i+1] = (z_reg[i] >= 0) ? b_reg[i] + db : b_reg[i] - db;
        assign z_next[i+1] = (z_reg[i] >= 0) ? z_reg[i] - ATAN_I : z_reg[i] + ATAN_I;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 0; i <= STAGES; i++)
        begin
            a_reg[i] <= a_next[i];
            b_reg[i] <= b_next[i];
            z_reg[i] <= z_next[i];
        end
        for (int i = 1; i <= STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Gain removal works on magnitudes, so the result truncates toward zero.
    logic signed [MW:0]   ae;
    logic signed [MW:0]   be;
    logic        [MW-1:0] mag_a_next;
    logic        [MW-1:0] mag_b_next;
    logic        [MW-1:0] mag_a_reg;
    logic        [MW-1:0] mag_b_reg;
    logic                 neg_a_reg;
    logic                 neg_b_reg;
    logic        [SW-1:0] mag_side_reg;
    logic                 mag_valid_reg;

    always_comb
    begin
        ae         = (MW + 1)'(a_reg[STAGES]);
        be         = (MW + 1)'(b_reg[STAGES]);
        mag_a_next = ae[MW] ? MW'(-ae) : MW'(ae);
        mag_b_next = be[MW] ? MW'(-be) : MW'(be);
    end

    logic [PHW-1:0] prod_ah_next;
    logic [PLW-1:0] prod_al_next;
    logic [PHW-1:0] prod_bh_next;
    logic [PLW-1:0] prod_bl_next;
    logic [PHW-1:0] prod_ah_reg;
    logic [PLW-1:0] prod_al_reg;
    logic [PHW-1:0] prod_bh_reg;
    logic [PLW-1:0] prod_bl_reg;
    logic           prod_neg_a_reg;
    logic           prod_neg_b_reg;
    logic [SW-1:0]  prod_side_reg;
    logic           prod_valid_reg;

    always_comb
    begin
        prod_ah_next = PHW'(mag_a_reg[MW-1:KQ_FRAC]) * PHW'(KQ);
        prod_al_next = PLW'(mag_a_reg[KQ_FRAC-1:0]) * PLW'(KQ);
        prod_bh_next = PHW'(mag_b_reg[MW-1:KQ_FRAC]) * PHW'(KQ);
        prod_bl_next = PLW'(mag_b_reg[KQ_FRAC-1:0]) * PLW'(KQ);
    end

    logic [RW-1:0] sum_a_next;
    logic [RW-1:0] sum_b_next;
    logic [RW-1:0] sum_a_reg;
    logic [RW-1:0] sum_b_reg;
    logic          sum_neg_a_reg;
    logic          sum_neg_b_reg;
    logic [SW-1:0] sum_side_reg;
    logic          sum_valid_reg;

    assign sum_a_next = RW'(prod_ah_reg) + RW'(prod_al_reg >> KQ_FRAC);
    assign sum_b_next = RW'(prod_bh_reg) + RW'(prod_bl_reg >> KQ_FRAC);

    logic signed [RW:0] sgn_a_next;
    logic signed [RW:0] sgn_b_next;
    logic signed [RW:0] sgn_a_reg;
    logic signed [RW:0] sgn_b_reg;
    logic        [SW-1:0] sgn_side_reg;
    logic               sgn_valid_reg;

    always_comb
    begin
        sgn_a_next = sum_neg_a_reg ? -$signed({1'b0, sum_a_reg}) : $signed({1'b0, sum_a_reg});
        sgn_b_next = sum_neg_b_reg ? -$signed({1'b0, sum_b_reg}) : $signed({1'b0, sum_b_reg});
    end

    // Drop the guard bits with round half up.
    logic signed [RW:0] rnd_a;
    logic signed [RW:0] rnd_b;

    always_comb
    begin
        rnd_a = (sgn_a_reg + RND_HALF) >>> GUARD;
        rnd_b = (sgn_b_reg + RND_HALF) >>> GUARD;
    end

    logic signed [OW-1:0] out_a_reg;
    logic signed [OW-1:0] out_b_reg;
    logic        [SW-1:0] out_side_reg;
    logic                 out_valid_reg;

    always_ff @(posedge clk)
    begin
        mag_a_reg      <= mag_a_next;
        mag_b_reg      <= mag_b_next;
        neg_a_reg      <= ae[MW];
        neg_b_reg      <= be[MW];
        mag_side_reg   <= side_reg[STAGES];
        prod_ah_reg    <= prod_ah_next;
        prod_al_reg    <= prod_al_next;
        prod_bh_reg    <= prod_bh_next;
        prod_bl_reg    <= prod_bl_next;
        prod_neg_a_reg <= neg_a_reg;
        prod_neg_b_reg <= neg_b_reg;
        prod_side_reg  <= mag_side_reg;
        sum_a_reg      <= sum_a_next;
        sum_b_reg      <= sum_b_next;
        sum_neg_a_reg  <= prod_neg_a_reg;
        sum_neg_b_reg  <= prod_neg_b_reg;
        sum_side_reg   <= prod_side_reg;
        sgn_a_reg      <= sgn_a_next;
        sgn_b_reg      <= sgn_b_next;
        sgn_side_reg   <= sum_side_reg;
        out_a_reg      <= rnd_a[OW-1:0];
        out_b_reg      <= rnd_b[OW-1:0];
        out_side_reg   <= sgn_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            sgn_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            v_reg          <= {v_reg[STAGES-1:0], in_valid};
            mag_valid_reg  <= v_reg[STAGES];
            prod_valid_reg <= mag_valid_reg;
            sum_valid_reg  <= prod_valid_reg;
            sgn_valid_reg  <= sum_valid_reg;
            out_valid_reg  <= sgn_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_side  = out_side_reg;

endmodule

@@ rtl/point_rotate_about_center.sv @@
// Top level: rotates a 3D point about a center, first about z by yaw, then about x by roll.
`timescale 1ns / 1ps

// One point enters every clock cycle: busy never rises, and a transfer takes
// place at each edge where start is high. Each result appears on out_x, out_y,
// out_z and saturated for exactly one cycle with done high; the receiver
// cannot stall the block, so results must be captured in the cycle they appear.
// The pipeline is one input register, two rotation pipelines of
// ROTATION_STAGES + 6 stages each (quadrant step, one CORDIC stage per
// iteration, magnitude, split gain multiply, sum, sign and rounding), and one
// output stage that adds the center back and saturates.
module point_rotate_about_center #(
    parameter int COORD_WIDTH     = 32,
    parameter int ANGLE_WIDTH     = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          saturated
);
    import prac_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int YIW  = CW + 1;
    localparam int YOW  = YIW + 2;
    localparam int RIW  = YOW;
    localparam int ROW  = RIW + 2;
    localparam int SUMW = CW + 6;
    localparam int YSW  = YIW + 3 * CW + ANGLE_WIDTH;
    localparam int RSW  = YOW + 3 * CW;
    localparam logic signed [SUMW-1:0] OUT_MAX =
        {{(SUMW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [SUMW-1:0] OUT_MIN =
        {{(SUMW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

    // Input stage: offsets from the center.
    logic signed [YIW-1:0]         dx_reg;
    logic signed [YIW-1:0]         dy_reg;
    logic signed [YIW-1:0]         dz_reg;
    logic signed [CW-1:0]          cx_reg;
    logic signed [CW-1:0]          cy_reg;
    logic signed [CW-1:0]          cz_reg;
    logic        [ANGLE_WIDTH-1:0] yaw_reg;
    logic        [ANGLE_WIDTH-1:0] roll_reg;
    logic                          in_valid_reg;
    logic                          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        dx_reg   <= YIW'(in_x) - YIW'(center_x);
        dy_reg   <= YIW'(in_y) - YIW'(center_y);
        dz_reg   <= YIW'(in_z) - YIW'(center_z);
        cx_reg   <= center_x;
        cy_reg   <= center_y;
        cz_reg   <= center_z;
        yaw_reg  <= yaw_angle;
        roll_reg <= roll_angle;
    end

    // Yaw turn in the x-y plane; z offset, centers and roll angle ride along.
    logic                  yaw_valid;
    logic signed [YOW-1:0] yaw_a;
    logic signed [YOW-1:0] yaw_b;
    logic        [YSW-1:0] yaw_side;
    logic signed [YIW-1:0] yaw_dz;
    logic signed [CW-1:0]  yaw_cx;
    logic signed [CW-1:0]  yaw_cy;
    logic signed [CW-1:0]  yaw_cz;
    logic [ANGLE_WIDTH-1:0] yaw_roll;

    prac_plane_rot #(
        .IW     (YIW),
        .AW     (ANGLE_WIDTH),
        .SW     (YSW),
        .STAGES (ROTATION_STAGES)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_a      (dx_reg),
        .in_b      (dy_reg),
        .in_ang    (yaw_reg),
        .in_side   ({dz_reg, cx_reg, cy_reg, cz_reg, roll_reg}),
        .out_valid (yaw_valid),
        .out_a     (yaw_a),
        .out_b     (yaw_b),
        .out_side  (yaw_side)
    );

    assign {yaw_dz, yaw_cx, yaw_cy, yaw_cz, yaw_roll} = yaw_side;

    // Roll turn in the y-z plane. The y offset from the yaw turn is exactly
    // the offset that re-centering on center_y would give, so it feeds in
    // directly at full width.
    logic                  roll_valid;
    logic signed [ROW-1:0] roll_a;
    logic signed [ROW-1:0] roll_b;
    logic        [RSW-1:0] roll_side;
    logic signed [YOW-1:0] roll_dx;
    logic signed [CW-1:0]  roll_cx;
    logic signed [CW-1:0]  roll_cy;
    logic signed [CW-1:0]  roll_cz;

    prac_plane_rot #(
        .IW     (RIW),
        .AW     (ANGLE_WIDTH),
        .SW     (RSW),
        .STAGES (ROTATION_STAGES)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yaw_valid),
        .in_a      (yaw_b),
        .in_b      (RIW'(yaw_dz)),
        .in_ang    (yaw_roll),
        .in_side   ({yaw_a, yaw_cx, yaw_cy, yaw_cz}),
        .out_valid (roll_valid),
        .out_a     (roll_a),
        .out_b     (roll_b),
        .out_side  (roll_side)
    );

    assign {roll_dx, roll_cx, roll_cy, roll_cz} = roll_side;

    // Output stage: restore the center and clamp to the coordinate range.
    logic signed [SUMW-1:0] sum_x;
    logic signed [SUMW-1:0] sum_y;
    logic signed [SUMW-1:0] sum_z;
    logic                   sat_x;
    logic                   sat_y;
    logic                   sat_z;
    logic signed [CW-1:0]   out_x_next;
    logic signed [CW-1:0]   out_y_next;
    logic signed [CW-1:0]   out_z_next;

    always_comb
    begin
        sum_x = SUMW'(roll_dx) + SUMW'(roll_cx);
        sum_y = SUMW'(roll_a) + SUMW'(roll_cy);
        sum_z = SUMW'(roll_b) + SUMW'(roll_cz);
        sat_x = (sum_x > OUT_MAX) || (sum_x < OUT_MIN);
        sat_y = (sum_y > OUT_MAX) || (sum_y < OUT_MIN);
        sat_z = (sum_z > OUT_MAX) || (sum_z < OUT_MIN);
        out_x_next = (sum_x > OUT_MAX) ? OUT_MAX[CW-1:0] :
                     (sum_x < OUT_MIN) ? OUT_MIN[CW-1:0] : sum_x[CW-1:0];
        out_y_next = (sum_y > OUT_MAX) ? OUT_MAX[CW-1:0] :
                     (sum_y < OUT_MIN) ? OUT_MIN[CW-1:0] : sum_y[CW-1:0];
        out_z_next = (sum_z > OUT_MAX) ? OUT_MAX[CW-1:0] :
                     (sum_z < OUT_MIN) ? OUT_MIN[CW-1:0] : sum_z[CW-1:0];
    end

    logic signed [CW-1:0] out_x_reg;
    logic signed [CW-1:0] out_y_reg;
    logic signed [CW-1:0] out_z_reg;
    logic                 sat_reg;
    logic                 done_reg;

    always_ff @(posedge clk)
    begin
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_z_reg <= out_z_next;
        sat_reg   <= sat_x || sat_y || sat_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= roll_valid;
        end
    end

    assign done      = done_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign saturated = sat_reg;

endmodule
